@@ rtl/lfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, marks and byte escaping for the LED frame packetizer.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam logic [7:0] MARK_START = 8'd94;
  localparam logic [7:0] MARK_END   = 8'd36;
  localparam logic [7:0] BYTE_ZERO  = 8'd0;
  localparam logic [7:0] BYTE_ONE   = 8'd1;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] brightness_in;
  } pixel_in_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] brightness_out;
    logic       frame_end;
  } pixel_out_t;

  typedef struct packed {
    logic bank;
  } cmd_t;

  function automatic logic [7:0] escape_byte(input logic [7:0] b);
    logic [7:0] r;
    if (b == BYTE_ZERO) begin
      r = BYTE_ONE;
    end else if (b == MARK_START) begin
      r = MARK_START + 8'd1;
    end else if (b == MARK_END) begin
      r = MARK_END + 8'd1;
    end else begin
      r = b;
    end
    return r;
  endfunction

  // red in bits 7..0, green 15..8, blue 23..16, brightness 31..24
  function automatic logic [31:0] escape_pixel(input pixel_in_t p);
    return {escape_byte(p.brightness_in), escape_byte(p.blue_in),
            escape_byte(p.green_in), escape_byte(p.red_in)};
  endfunction

endpackage

@@ rtl/lfp_ram.sv @@
// ----------------------------------------------------------------------------
// lfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lfp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lfp_front.sv @@
// ----------------------------------------------------------------------------
// lfp_front
// Accepts pixels, escapes them into the pending bank and compares each one
// with the kept frame; issues an emit command when a changed frame completes.
// ----------------------------------------------------------------------------
module lfp_front #(
  parameter int MAX_PIXELS = 64,
  parameter int IDX_W      = 6,
  parameter int LEN_W      = 7,
  parameter int AW         = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_data,
  input  lfp_pkg::pixel_in_t pixel,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [31:0]       ram_wdata,
  output logic [AW-1:0]     ram_raddr,
  input  logic [31:0]       ram_rdata,
  output lfp_pkg::cmd_t     cmd,
  output logic              cmd_push,
  input  logic              cmd_empty,
  input  logic              back_busy,
  output logic [LEN_W-1:0]  frame_len
);
  import lfp_pkg::*;

  localparam int CW = (LEN_W > 7) ? LEN_W : 7;

  logic [6:0]       pixel_count;
  logic [IDX_W-1:0] pixel_index;
  logic             frame_differs;
  logic             sent_valid;
  logic             bank_select;
  logic             s1_valid;
  logic             s1_last;
  logic [31:0]      s1_word;

  logic             accept;
  logic [CW-1:0]    count_ext;
  logic [LEN_W:0]   len_ext;
  logic [IDX_W-1:0] pos;
  logic             last;
  logic             differs_now;

  always_comb begin
    count_ext = CW'(pixel_count);
    if (pixel_count == 7'd0) begin
      frame_len = LEN_W'(1);
    end else if (count_ext > CW'(MAX_PIXELS)) begin
      frame_len = LEN_W'(MAX_PIXELS);
    end else begin
      frame_len = LEN_W'(count_ext);
    end
  end

  assign len_ext     = (LEN_W + 1)'(frame_len);
  assign pos         = ((LEN_W + 1)'(pixel_index) >= len_ext) ? '0 : pixel_index;
  assign last        = ((LEN_W + 1)'(pos) + (LEN_W + 1)'(1)) >= len_ext;
  assign pixel_stall = (s1_valid && s1_last) || !cmd_empty || back_busy;
  assign accept      = pixel_valid && !pixel_stall;

  assign ram_we    = accept;
  assign ram_waddr = {~bank_select, pos};
  assign ram_wdata = escape_pixel(pixel);
  assign ram_raddr = {bank_select, pos};

  assign differs_now = frame_differs || !sent_valid || (ram_rdata != s1_word);
  assign cmd_push    = s1_valid && s1_last && differs_now;
  assign cmd.bank    = ~bank_select;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count   <= 7'd64;
      pixel_index   <= '0;
      frame_differs <= 1'b0;
      sent_valid    <= 1'b0;
      bank_select   <= 1'b0;
      s1_valid      <= 1'b0;
    end else if (cfg_we) begin
      pixel_count   <= cfg_data;
      pixel_index   <= '0;
      frame_differs <= 1'b0;
      sent_valid    <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        pixel_index <= last ? '0 : pos + IDX_W'(1);
      end
      if (s1_valid) begin
        frame_differs <= s1_last ? 1'b0 : differs_now;
      end
      if (cmd_push) begin
        sent_valid  <= 1'b1;
        bank_select <= ~bank_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= last;
      s1_word <= ram_wdata;
    end
  end

endmodule

@@ rtl/lfp_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// lfp_cmd_fifo
// Two-entry queue of emit commands between front and back.
// ----------------------------------------------------------------------------
module lfp_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lfp_pkg::cmd_t push_data,
  input  logic          pop,
  output lfp_pkg::cmd_t pop_data,
  output logic          empty,
  output logic          full
);
  import lfp_pkg::*;

  cmd_t       entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

@@ rtl/lfp_back.sv @@
// ----------------------------------------------------------------------------
// lfp_back
// Reads a completed frame from its bank and streams it out pixel by pixel
// through an output register, flagging the first and last pixel.
// ----------------------------------------------------------------------------
module lfp_back #(
  parameter int IDX_W = 6,
  parameter int LEN_W = 7,
  parameter int AW    = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  lfp_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic [LEN_W-1:0]   frame_len,
  output logic               rd_en,
  output logic [AW-1:0]      raddr,
  input  logic [31:0]        rdata,
  output logic               busy,
  output lfp_pkg::pixel_out_t result,
  output logic               result_valid,
  input  logic               result_stall
);
  import lfp_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state;
  logic             state_next;
  logic             bank;
  logic [LEN_W-1:0] k;
  logic             rd_pend;
  logic             rd_first;
  logic             rd_last;
  logic             out_free;

  assign out_free = !result_valid || !result_stall;
  assign busy     = (state == ST_RUN);
  assign cmd_pop  = (state == ST_IDLE) && !cmd_empty;
  assign rd_en    = (state == ST_RUN) && (k != frame_len) && !rd_pend && out_free;
  assign raddr    = {bank, k[IDX_W-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if ((k == frame_len) && !rd_pend) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rd_pend      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (rd_pend) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      bank <= cmd.bank;
      k    <= '0;
    end else if (rd_en) begin
      k <= k + LEN_W'(1);
    end
    if (rd_en) begin
      rd_first <= (k == '0);
      rd_last  <= ((k + LEN_W'(1)) == frame_len);
    end
    if (rd_pend) begin
      result.frame_start    <= rd_first;
      result.red_out        <= rdata[7:0];
      result.green_out      <= rdata[15:8];
      result.blue_out       <= rdata[23:16];
      result.brightness_out <= rdata[31:24];
      result.frame_end      <= rd_last;
    end
  end

endmodule

@@ rtl/led_frame_packetizer_dedup.sv @@
// ----------------------------------------------------------------------------
// led_frame_packetizer_dedup
// LED frame packetizer with byte escaping and suppression of repeated frames.
// ----------------------------------------------------------------------------
// Pixels are taken at one per cycle while a frame loads: each is escaped
// (0 to 1, 94 to 95, 36 to 37), written to the pending bank of a two-bank RAM
// and compared with the kept frame in the next cycle; after the last pixel,
// input is stalled for the compare. If the frame changed, or none was sent
// since reset or the last pixel_count write, the whole frame is emitted; each
// read of the shared RAM port waits for the registered data of the one before,
// and input is stalled until the last read is done. An unchanged frame emits
// nothing. Writing pixel_count drops a partial frame and forgets the kept one.
module led_frame_packetizer_dedup #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data,
  input  lfp_pkg::pixel_in_t  pixel,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  output lfp_pkg::pixel_out_t result,
  output logic                result_valid,
  input  logic                result_stall
);
  import lfp_pkg::*;

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int LEN_W = $clog2(MAX_PIXELS + 1);
  localparam int AW    = IDX_W + 1;
  localparam int DEPTH = 2 << IDX_W;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [31:0]      ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [AW-1:0]    front_raddr;
  logic [AW-1:0]    back_raddr;
  logic             back_rd_en;
  logic [31:0]      ram_rdata;
  cmd_t             push_cmd;
  cmd_t             pop_cmd;
  logic             cmd_push;
  logic             cmd_pop;
  logic             cmd_empty;
  logic             cmd_full;
  logic             back_busy;
  logic [LEN_W-1:0] frame_len;

  assign ram_raddr = back_rd_en ? back_raddr : front_raddr;

  lfp_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lfp_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .IDX_W      (IDX_W),
    .LEN_W      (LEN_W),
    .AW         (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (front_raddr),
    .ram_rdata   (ram_rdata),
    .cmd         (push_cmd),
    .cmd_push    (cmd_push),
    .cmd_empty   (cmd_empty),
    .back_busy   (back_busy),
    .frame_len   (frame_len)
  );

  lfp_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (push_cmd),
    .pop       (cmd_pop),
    .pop_data  (pop_cmd),
    .empty     (cmd_empty),
    .full      (cmd_full)
  );

  lfp_back #(
    .IDX_W (IDX_W),
    .LEN_W (LEN_W),
    .AW    (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd          (pop_cmd),
    .cmd_empty    (cmd_empty),
    .cmd_pop      (cmd_pop),
    .frame_len    (frame_len),
    .rd_en        (back_rd_en),
    .raddr        (back_raddr),
    .rdata        (ram_rdata),
    .busy         (back_busy),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall || (cmd_full && !result_valid))
  );

endmodule

@@ test/lfp_frame_checker.sv @@
// ----------------------------------------------------------------------------
// lfp_frame_checker
// Watches the configuration, pixel and result channels of the LED frame
// packetizer. Keeps its own copy of the loading frame and the kept frame,
// escapes each accepted pixel, decides at the end of each frame whether it
// is emitted or suppressed as a repeat, and compares every emitted pixel
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module lfp_frame_checker #(
  parameter int MAX_PIXELS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_data,
  input  lfp_pkg::pixel_in_t  pixel,
  input  logic                pixel_valid,
  input  logic                pixel_stall,
  input  lfp_pkg::pixel_out_t result,
  input  logic                result_valid,
  input  logic                result_stall,
  output int                  failures,
  output int                  pending,
  output int                  frames_sent,
  output int                  frames_dropped
);
  import lfp_pkg::*;

  logic [31:0] kept_frame    [MAX_PIXELS];
  logic [31:0] loading_frame [MAX_PIXELS];
  int unsigned load_pos;
  bit          frame_changed;
  bit          kept_valid;
  logic [6:0]  frame_pixels;
  pixel_out_t  expected_pixels [$];

  function automatic logic [7:0] stuff_byte(input logic [7:0] b);
    case (b)
      BYTE_ZERO:          return BYTE_ONE;
      MARK_START, MARK_END: return b + 8'd1;
      default:            return b;
    endcase
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (failures < 100) begin
      $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    end
    failures++;
  endtask

  always @(posedge clk) begin : predict
    int unsigned len;
    int unsigned pos;
    logic [31:0] word;
    pixel_out_t  want;
    pixel_out_t  px;
    if (rst) begin
      load_pos       = 0;
      frame_changed  = 1'b0;
      kept_valid     = 1'b0;
      frame_pixels   = 7'd64;
      failures       = 0;
      frames_sent    = 0;
      frames_dropped = 0;
      expected_pixels.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          want = expected_pixels.pop_front();
          if (result.frame_start != want.frame_start)
            report("frame_start", result.frame_start, want.frame_start);
          if (result.red_out != want.red_out)
            report("red_out", result.red_out, want.red_out);
          if (result.green_out != want.green_out)
            report("green_out", result.green_out, want.green_out);
          if (result.blue_out != want.blue_out)
            report("blue_out", result.blue_out, want.blue_out);
          if (result.brightness_out != want.brightness_out)
            report("brightness_out", result.brightness_out, want.brightness_out);
          if (result.frame_end != want.frame_end)
            report("frame_end", result.frame_end, want.frame_end);
        end
      end

      if (cfg_we) begin
        frame_pixels  = cfg_data;
        kept_valid    = 1'b0;
        load_pos      = 0;
        frame_changed = 1'b0;
      end

      if (pixel_valid && !pixel_stall) begin
        len = (frame_pixels == 7'd0) ? 1 :
              (frame_pixels > MAX_PIXELS) ? MAX_PIXELS : frame_pixels;
        pos = (load_pos >= len) ? 0 : load_pos;
        word = {stuff_byte(pixel.brightness_in), stuff_byte(pixel.blue_in),
                stuff_byte(pixel.green_in), stuff_byte(pixel.red_in)};
        loading_frame[pos] = word;
        if (!kept_valid || kept_frame[pos] != word) frame_changed = 1'b1;
        if (pos + 1 < len) begin
          load_pos = pos + 1;
        end else begin
          load_pos = 0;
          if (frame_changed) begin
            frame_changed = 1'b0;
            for (int k = 0; k < len; k++) begin
              kept_frame[k]     = loading_frame[k];
              px.frame_start    = (k == 0);
              px.red_out        = loading_frame[k][7:0];
              px.green_out      = loading_frame[k][15:8];
              px.blue_out       = loading_frame[k][23:16];
              px.brightness_out = loading_frame[k][31:24];
              px.frame_end      = (k + 1 == len);
              expected_pixels.insert(expected_pixels.size(), px);
            end
            kept_valid = 1'b1;
            frames_sent++;
          end else begin
            frames_dropped++;
          end
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the LED frame packetizer: directed frames with marker and
// zero bytes, exact repeats, repeats that differ only before escaping, edited
// frames, partial frames cut by a size write, then random phases over small
// frame sizes and one full-size frame at an oversize setting. Bursty sender,
// patterned receiver stall with one long hold-off; the checker predicts and
// counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
  import lfp_pkg::*;

  localparam int MAX_PIXELS = 64;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {NEW_FRAME, SAME_FRAME, TWIN_FRAME, EDIT_FRAME} frame_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;
  pixel_in_t  pixel = '0;
  logic       pixel_valid = 1'b0;
  logic       pixel_stall;
  pixel_out_t result;
  logic       result_valid;
  logic       result_stall = 1'b0;

  int failures;
  int pending;
  int frames_sent;
  int frames_dropped;
  int pixels_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  pixel_in_t last_frame [MAX_PIXELS];

  always #5 clk = ~clk;

  led_frame_packetizer_dedup #(.MAX_PIXELS(MAX_PIXELS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .pixel        (pixel),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  lfp_frame_checker #(.MAX_PIXELS(MAX_PIXELS)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .pixel          (pixel),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .result         (result),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .failures       (failures),
    .pending        (pending),
    .frames_sent    (frames_sent),
    .frames_dropped (frames_dropped)
  );

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return BYTE_ZERO;
      1:       return BYTE_ONE;
      2:       return MARK_START;
      3:       return MARK_START + 8'd1;
      4:       return MARK_END;
      5:       return MARK_END + 8'd1;
      6:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // swap a byte for the other one that escapes to the same value
  function automatic logic [7:0] twin_byte(input logic [7:0] b);
    case (b)
      BYTE_ZERO:          return BYTE_ONE;
      BYTE_ONE:           return BYTE_ZERO;
      MARK_START:         return MARK_START + 8'd1;
      MARK_START + 8'd1:  return MARK_START;
      MARK_END:           return MARK_END + 8'd1;
      MARK_END + 8'd1:    return MARK_END;
      default:            return b;
    endcase
  endfunction

  task automatic send_pixel(input pixel_in_t p);
    int gap;
    pixel       <= p;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic send_frame(input int count, input frame_kind_t kind);
    int spot;
    spot = $urandom_range(0, count - 1);
    for (int i = 0; i < count; i++) begin
      case (kind)
        NEW_FRAME:  last_frame[i] = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        TWIN_FRAME: last_frame[i] = {twin_byte(last_frame[i].red_in),
                                     twin_byte(last_frame[i].green_in),
                                     twin_byte(last_frame[i].blue_in),
                                     twin_byte(last_frame[i].brightness_in)};
        EDIT_FRAME: begin
          if (i == spot) begin
            case ($urandom_range(0, 3))
              0:       last_frame[i].red_in += 8'd2;
              1:       last_frame[i].green_in += 8'd2;
              2:       last_frame[i].blue_in += 8'd2;
              default: last_frame[i].brightness_in += 8'd2;
            endcase
          end
        end
        default: ;
      endcase
      send_pixel(last_frame[i]);
    end
  endtask

  // drop valid, wait for the output to drain and the compare to finish
  task automatic settle();
    if (pixel_valid) pixel_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_frame_size(input logic [6:0] n);
    settle();
    cfg_data <= n;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin : receiver
    int mode;
    int mode_left;
    int seen;
    bit held;
    mode_left = 0;
    seen = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (result_valid) seen++;
      if (!held && seen >= 16 && pixel_valid) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 40);
        end
        mode_left--;
        case (mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          default: result_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[led_frame_packetizer_dedup] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int size;
    int len;
    int frames;
    int random_items;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 12);

    // markers, zero and all-ones in every lane
    set_frame_size(7'd4);
    last_frame[0] = {BYTE_ZERO, MARK_START, MARK_END, 8'hFF};
    last_frame[1] = {MARK_START, MARK_END, 8'hFF, BYTE_ZERO};
    last_frame[2] = {MARK_END, 8'hFF, BYTE_ZERO, MARK_START};
    last_frame[3] = {8'hFF, BYTE_ZERO, MARK_START, MARK_END};
    send_frame(4, SAME_FRAME);
    send_frame(4, SAME_FRAME);
    send_frame(4, TWIN_FRAME);

    set_frame_size(7'd1);
    last_frame[0] = {BYTE_ONE, MARK_START + 8'd1, MARK_END + 8'd1, 8'hFE};
    send_frame(1, SAME_FRAME);
    send_frame(1, SAME_FRAME);
    send_frame(1, EDIT_FRAME);

    set_frame_size(7'd0);
    send_frame(1, NEW_FRAME);
    send_frame(1, SAME_FRAME);

    // partial frame dropped by a size write; kept frame is forgotten
    set_frame_size(7'd3);
    send_frame(3, NEW_FRAME);
    send_frame(2, SAME_FRAME);
    set_frame_size(7'd3);
    send_frame(3, SAME_FRAME);

    random_items = 0;
    while (random_items < 16) begin
      case ($urandom_range(0, 9))
        0:       size = 0;
        default: size = $urandom_range(1, 8);
      endcase
      len = (size == 0) ? 1 : size;
      set_frame_size(7'(size));
      send_frame(len, NEW_FRAME);
      random_items += len;
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3:             send_frame(len, NEW_FRAME);
          4, 5, 6, 7, 8:          send_frame(len, EDIT_FRAME);
          9, 10, 11, 12:          send_frame(len, TWIN_FRAME);
          default:                send_frame(len, SAME_FRAME);
        endcase
        random_items += len;
      end
      if (len > 1 && $urandom_range(0, 5) == 0) begin
        send_frame($urandom_range(1, len - 1), NEW_FRAME);
      end
    end

    // full-size frame; the oversize setting clamps to the largest length
    set_frame_size(7'd127);
    send_frame(MAX_PIXELS, NEW_FRAME);

    settle();
    $display("run: %0d pixels in, %0d frames emitted, %0d repeats suppressed",
             pixels_sent, frames_sent, frames_dropped);
    $display("frame sizes 0 to 8 and 127 (clamped to 64) with marker, zero and twin bytes");
    if (failures == 0) begin
      $display("[led_frame_packetizer_dedup] OK");
    end else begin
      $display("[led_frame_packetizer_dedup] ERROR");
    end
    $finish;
  end

endmodule
